FILE: hdl/ukl_pkg.sv
// Shared types, codes and default sizes for the unique key list table.
`timescale 1ns / 1ps

package ukl_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int KEY_WIDTH_DEF = 32;

    localparam int OP_W     = 3;
    localparam int KEY_W    = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 3'd0,
        OP_DEL_KEY = 3'd1,
        OP_DEL_AT  = 3'd2,
        OP_READ_AT = 3'd3,
        OP_FIND    = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_MISSING = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        status_t            status;
        logic               found;
        logic [POS_W-1:0]   found_index;
        logic [KEY_W-1:0]   key_out;
        logic [COUNT_W-1:0] count;
    } res_t;

endpackage

FILE: hdl/ukl_if.sv
// Request and response channel interfaces of the unique key list table.
`timescale 1ns / 1ps

interface ukl_req_if;
    logic                      valid;
    logic                      ready;
    logic [ukl_pkg::OP_W-1:0]  operation;
    logic [ukl_pkg::KEY_W-1:0] key;
    logic [ukl_pkg::POS_W-1:0] position;

    modport source (output valid, operation, key, position, input ready);
    modport sink (input valid, operation, key, position, output ready);
endinterface

interface ukl_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ukl_pkg::STATUS_W-1:0] status;
    logic                         found;
    logic [ukl_pkg::POS_W-1:0]    found_index;
    logic [ukl_pkg::KEY_W-1:0]    key_out;
    logic [ukl_pkg::COUNT_W-1:0]  count;

    modport source (output valid, status, found, found_index, key_out, count, input ready);
    modport sink (input valid, status, found, found_index, key_out, count, output ready);
endinterface

FILE: hdl/ukl_ram.sv
// Key storage: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module ukl_ram #(
    parameter int DEPTH = ukl_pkg::CAPACITY_DEF,
    parameter int WIDTH = ukl_pkg::KEY_WIDTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/ukl_ctrl.sv
// Sequencer that scans, reads and compacts the key storage for each request.
`timescale 1ns / 1ps

module ukl_ctrl #(
    parameter int CAPACITY  = ukl_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = ukl_pkg::KEY_WIDTH_DEF,
    localparam int IW       = $clog2(CAPACITY),
    localparam int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ukl_req_if.sink              req,
    output logic                 res_valid,
    input  logic                 res_ready,
    output ukl_pkg::res_t        res,
    output logic                 mem_we,
    output logic [IW-1:0]        mem_waddr,
    output logic [KEY_WIDTH-1:0] mem_wdata,
    output logic [IW-1:0]        mem_raddr,
    input  logic [KEY_WIDTH-1:0] mem_rdata
);

    localparam int KEEP = (KEY_WIDTH < ukl_pkg::KEY_W) ? KEY_WIDTH : ukl_pkg::KEY_W;
    localparam int PW   = (CW > ukl_pkg::POS_W) ? CW : ukl_pkg::POS_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_FETCH = 5'b00100,
        S_SHIFT = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic [CW-1:0]              count_reg, count_next;
    ukl_pkg::op_t               op_reg, op_next;
    logic [KEY_WIDTH-1:0]       key_reg, key_next;
    logic [IW-1:0]              ptr_reg, ptr_next;
    ukl_pkg::status_t           status_reg, status_next;
    logic                       found_reg, found_next;
    logic [IW-1:0]              idx_reg, idx_next;
    logic [ukl_pkg::KEY_W-1:0]  kout_reg, kout_next;

    logic [KEY_WIDTH-1:0]       key_in;
    logic [CW-1:0]              ptr_ext, ptr_inc1, ptr_inc2;
    logic                       pos_ok;

    assign key_in   = KEY_WIDTH'(req.key[KEEP-1:0]);
    assign ptr_ext  = CW'(ptr_reg);
    assign ptr_inc1 = ptr_ext + CW'(1);
    assign ptr_inc2 = ptr_ext + CW'(2);
    assign pos_ok   = PW'(req.position) < PW'(count_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        ptr_next    = ptr_reg;
        status_next = status_reg;
        found_next  = found_reg;
        idx_next    = idx_reg;
        kout_next   = kout_reg;
        req.ready   = 1'b0;
        res_valid   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = ptr_reg;
        mem_wdata   = mem_rdata;
        // The entry after the current pointer is fetched by default; a removal
        // that starts in this cycle needs exactly that entry next.
        mem_raddr   = ptr_inc1[IW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    op_next     = ukl_pkg::op_t'(req.operation);
                    key_next    = key_in;
                    status_next = ukl_pkg::ST_MISSING;
                    found_next  = 1'b0;
                    idx_next    = '0;
                    kout_next   = '0;
                    state_next  = S_DONE;
                    case (ukl_pkg::op_t'(req.operation))
                        ukl_pkg::OP_ADD, ukl_pkg::OP_DEL_KEY, ukl_pkg::OP_FIND:
                        begin
                            if (count_reg == '0)
                            begin
                                if (ukl_pkg::op_t'(req.operation) == ukl_pkg::OP_ADD)
                                begin
                                    mem_we      = 1'b1;
                                    mem_waddr   = '0;
                                    mem_wdata   = key_in;
                                    count_next  = CW'(1);
                                    status_next = ukl_pkg::ST_DONE;
                                end
                            end
                            else
                            begin
                                mem_raddr  = '0;
                                ptr_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        ukl_pkg::OP_DEL_AT, ukl_pkg::OP_READ_AT:
                        begin
                            if (pos_ok)
                            begin
                                mem_raddr  = IW'(req.position);
                                ptr_next   = IW'(req.position);
                                state_next = S_FETCH;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (mem_rdata == key_reg)
                begin
                    found_next = 1'b1;
                    idx_next   = ptr_reg;
                    kout_next  = ukl_pkg::KEY_W'(mem_rdata[KEEP-1:0]);
                    state_next = S_DONE;
                    if (op_reg == ukl_pkg::OP_ADD)
                    begin
                        status_next = ukl_pkg::ST_PRESENT;
                    end
                    else
                    begin
                        status_next = ukl_pkg::ST_DONE;
                        if (op_reg == ukl_pkg::OP_DEL_KEY)
                        begin
                            if (ptr_inc1 < count_reg)
                            begin
                                state_next = S_SHIFT;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                    end
                end
                else if (ptr_inc1 < count_reg)
                begin
                    ptr_next = ptr_inc1[IW-1:0];
                end
                else
                begin
                    state_next = S_DONE;
                    if (op_reg == ukl_pkg::OP_ADD)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            status_next = ukl_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_we      = 1'b1;
                            mem_waddr   = count_reg[IW-1:0];
                            mem_wdata   = key_reg;
                            count_next  = count_reg + CW'(1);
                            status_next = ukl_pkg::ST_DONE;
                        end
                    end
                end
            end

            S_FETCH:
            begin
                found_next  = 1'b1;
                idx_next    = ptr_reg;
                kout_next   = ukl_pkg::KEY_W'(mem_rdata[KEEP-1:0]);
                status_next = ukl_pkg::ST_DONE;
                state_next  = S_DONE;
                if (op_reg == ukl_pkg::OP_DEL_AT)
                begin
                    if (ptr_inc1 < count_reg)
                    begin
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end

            S_SHIFT:
            begin
                // The read data holds the entry one above the write pointer.
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = mem_rdata;
                if (ptr_inc2 < count_reg)
                begin
                    mem_raddr = ptr_inc2[IW-1:0];
                    ptr_next  = ptr_inc1[IW-1:0];
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        ptr_reg    <= ptr_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        idx_reg    <= idx_next;
        kout_reg   <= kout_next;
    end

    assign res.status      = status_reg;
    assign res.found       = found_reg;
    assign res.found_index = ukl_pkg::POS_W'(idx_reg);
    assign res.key_out     = kout_reg;
    assign res.count       = ukl_pkg::COUNT_W'(count_reg);

endmodule

FILE: hdl/unique_key_list_table.sv
// Read at index goes through the fetch and done states to the response register; add,
// find and delete by key scan one entry per cycle; a delete moves each later entry down.
// One request is handled at a time; a new one is taken only while the sequencer is idle.
// A finished response waits in its own register while the next request is taken.
// Reset clears the entry count and the sequencer; the key storage itself is not cleared.
`timescale 1ns / 1ps

module unique_key_list_table #(
    parameter int CAPACITY  = ukl_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = ukl_pkg::KEY_WIDTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    ukl_req_if.sink  req,
    ukl_rsp_if.source rsp
);

    localparam int IW = $clog2(CAPACITY);

    logic                 res_valid;
    logic                 res_ready;
    ukl_pkg::res_t        res;
    logic                 mem_we;
    logic [IW-1:0]        mem_waddr;
    logic [KEY_WIDTH-1:0] mem_wdata;
    logic [IW-1:0]        mem_raddr;
    logic [KEY_WIDTH-1:0] mem_rdata;

    logic                 out_valid_reg, out_valid_next;
    ukl_pkg::res_t        out_data_reg;

    ukl_ctrl #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ukl_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The response register takes a new result whenever it is empty or being drained.
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_data_reg.status;
    assign rsp.found       = out_data_reg.found;
    assign rsp.found_index = out_data_reg.found_index;
    assign rsp.key_out     = out_data_reg.key_out;
    assign rsp.count       = out_data_reg.count;

endmodule

FILE: dv/unique_key_list_table_tb.sv
// Self-checking testbench for the unique key list table: directed table, then random requests.
`timescale 1ns / 1ps

module unique_key_list_table_tb;

    localparam int DEPTH = ukl_pkg::CAPACITY_DEF;
    localparam int RANDOM_REQUESTS = 800;

    localparam int OP_W    = ukl_pkg::OP_W;
    localparam int KEY_W   = ukl_pkg::KEY_W;
    localparam int POS_W   = ukl_pkg::POS_W;
    localparam int COUNT_W = ukl_pkg::COUNT_W;

    // Operation codes that the block does not define.
    localparam logic [OP_W-1:0] OP_RESV5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RESV6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RESV7 = 3'd7;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] pos;
        int               copies;
        bit               typed;
        ukl_pkg::res_t    want;
    } plan_row_t;

    logic clk;
    logic rst_n;

    ukl_req_if req_ch ();
    ukl_rsp_if rsp_ch ();

    unique_key_list_table DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the table contents.
    logic [KEY_W-1:0] shadow_keys [DEPTH];
    int unsigned      shadow_count;

    ukl_pkg::res_t pending_results [$];
    plan_row_t     plan [$];
    int            errors;
    bit            quiet;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic bit take_break();
        return !quiet && ($urandom_range(0, 99) < 25);
    endfunction

    function automatic int lookup_key(logic [KEY_W-1:0] k);
        int hit;
        hit = -1;
        for (int i = 0; i < shadow_count; i++)
            if (hit < 0 && shadow_keys[i] == k)
                hit = i;
        return hit;
    endfunction

    function automatic void remove_entry(int idx);
        for (int i = idx; i + 1 < shadow_count; i++)
            shadow_keys[i] = shadow_keys[i + 1];
        shadow_count--;
    endfunction

    function automatic ukl_pkg::res_t apply_request(logic [OP_W-1:0] op,
                                                    logic [KEY_W-1:0] k,
                                                    logic [POS_W-1:0] pos);
        ukl_pkg::res_t r;
        int            idx;
        r = '0;
        r.status = ukl_pkg::ST_MISSING;
        case (op)
            ukl_pkg::OP_ADD:
            begin
                idx = lookup_key(k);
                if (idx >= 0)
                begin
                    r.status      = ukl_pkg::ST_PRESENT;
                    r.found       = 1'b1;
                    r.found_index = POS_W'(idx);
                    r.key_out     = shadow_keys[idx];
                end
                else if (shadow_count >= DEPTH)
                    r.status = ukl_pkg::ST_FULL;
                else
                begin
                    shadow_keys[shadow_count] = k;
                    shadow_count++;
                    r.status = ukl_pkg::ST_DONE;
                end
            end
            ukl_pkg::OP_DEL_KEY, ukl_pkg::OP_FIND:
            begin
                idx = lookup_key(k);
                if (idx >= 0)
                begin
                    r.status      = ukl_pkg::ST_DONE;
                    r.found       = 1'b1;
                    r.found_index = POS_W'(idx);
                    r.key_out     = shadow_keys[idx];
                    if (op == ukl_pkg::OP_DEL_KEY)
                        remove_entry(idx);
                end
            end
            ukl_pkg::OP_DEL_AT, ukl_pkg::OP_READ_AT:
            begin
                if (pos < shadow_count)
                begin
                    r.status      = ukl_pkg::ST_DONE;
                    r.found       = 1'b1;
                    r.found_index = pos;
                    r.key_out     = shadow_keys[pos];
                    if (op == ukl_pkg::OP_DEL_AT)
                        remove_entry(int'(pos));
                end
            end
            default:
            begin
            end
        endcase
        r.count = COUNT_W'(shadow_count);
        return r;
    endfunction

    function automatic plan_row_t plan_row(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                           logic [POS_W-1:0] pos, int copies, bit typed,
                                           ukl_pkg::res_t want);
        plan_row_t row;
        row.op     = op;
        row.key    = key;
        row.pos    = pos;
        row.copies = copies;
        row.typed  = typed;
        row.want   = want;
        return row;
    endfunction

    // Entered and left at a falling edge; the shadow table is updated on acceptance.
    task automatic issue(logic [OP_W-1:0] op, logic [KEY_W-1:0] key, logic [POS_W-1:0] pos,
                         bit typed, ukl_pkg::res_t want);
        ukl_pkg::res_t predicted;
        while (take_break())
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.key       <= key;
        req_ch.position  <= pos;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        predicted = apply_request(op, key, pos);
        pending_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic check_response(ukl_pkg::res_t got);
        ukl_pkg::res_t want;
        if (pending_results.size() == 0)
        begin
            $display("%0t: response with no request outstanding: status %0d count %0d",
                     $time, got.status, got.count);
            errors++;
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.found !== want.found)
            begin
                $display("%0t: found expected %0b actual %0b", $time, want.found, got.found);
                errors++;
            end
            if (got.found_index !== want.found_index)
            begin
                $display("%0t: found_index expected %0d actual %0d", $time,
                         want.found_index, got.found_index);
                errors++;
            end
            if (got.key_out !== want.key_out)
            begin
                $display("%0t: key_out expected %h actual %h", $time, want.key_out, got.key_out);
                errors++;
            end
            if (got.count !== want.count)
            begin
                $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
                errors++;
            end
        end
    endtask

    // Response side: ready changes at the falling edge, responses are taken at the rising edge.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n)
                rsp_ch.ready <= !take_break();
        end
    end

    initial
    begin
        ukl_pkg::res_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got.status      = ukl_pkg::status_t'(rsp_ch.status);
                got.found       = rsp_ch.found;
                got.found_index = rsp_ch.found_index;
                got.key_out     = rsp_ch.key_out;
                got.count       = rsp_ch.count;
                check_response(got);
            end
        end
    end

    initial
    begin
        int               accepted;
        int               pick;
        bit               filling;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] pos;

        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = '0;
        req_ch.key       = '0;
        req_ch.position  = '0;
        errors           = 0;
        quiet            = 1'b0;
        shadow_count     = 0;
        for (int i = 0; i < DEPTH; i++)
            shadow_keys[i] = '0;

        plan.push_back(plan_row(ukl_pkg::OP_READ_AT, 32'h0, 4'd0, 1, 1,
                                ukl_pkg::res_t'{ukl_pkg::ST_MISSING, 1'b0, 4'd0, 32'h0,
                                                5'd0}));
        plan.push_back(plan_row(OP_RESV7, 32'hFFFF_FFFF, 4'd15, 1, 1,
                                ukl_pkg::res_t'{ukl_pkg::ST_MISSING, 1'b0, 4'd0, 32'h0,
                                                5'd0}));
        plan.push_back(plan_row(ukl_pkg::OP_ADD, 32'h0, 4'd0, 1, 1,
                                ukl_pkg::res_t'{ukl_pkg::ST_DONE, 1'b0, 4'd0, 32'h0, 5'd1}));
        plan.push_back(plan_row(ukl_pkg::OP_ADD, 32'h0, 4'd15, 1, 1,
                                ukl_pkg::res_t'{ukl_pkg::ST_PRESENT, 1'b1, 4'd0, 32'h0,
                                                5'd1}));
        plan.push_back(plan_row(ukl_pkg::OP_ADD, 32'hFFFF_FFFF, 4'd0, 1, 1,
                                ukl_pkg::res_t'{ukl_pkg::ST_DONE, 1'b0, 4'd0, 32'h0, 5'd2}));
        plan.push_back(plan_row(ukl_pkg::OP_FIND, 32'hFFFF_FFFF, 4'd0, 1, 1,
                                ukl_pkg::res_t'{ukl_pkg::ST_DONE, 1'b1, 4'd1, 32'hFFFF_FFFF,
                                                5'd2}));
        // Fill the remaining places with consecutive keys.
        plan.push_back(plan_row(ukl_pkg::OP_ADD, 32'h0000_1000, 4'd0, 14, 0, '0));
        plan.push_back(plan_row(ukl_pkg::OP_ADD, 32'hDEAD_BEEF, 4'd0, 1, 1,
                                ukl_pkg::res_t'{ukl_pkg::ST_FULL, 1'b0, 4'd0, 32'h0, 5'd16}));
        plan.push_back(plan_row(ukl_pkg::OP_READ_AT, 32'h0, 4'd15, 1, 0, '0));
        plan.push_back(plan_row(ukl_pkg::OP_DEL_KEY, 32'hFFFF_FFFF, 4'd0, 1, 0, '0));
        plan.push_back(plan_row(ukl_pkg::OP_DEL_AT, 32'h0, 4'd0, 1, 0, '0));
        plan.push_back(plan_row(ukl_pkg::OP_DEL_AT, 32'h0, 4'd15, 1, 1,
                                ukl_pkg::res_t'{ukl_pkg::ST_MISSING, 1'b0, 4'd0, 32'h0,
                                                5'd14}));
        plan.push_back(plan_row(ukl_pkg::OP_DEL_KEY, 32'hDEAD_BEEF, 4'd0, 1, 1,
                                ukl_pkg::res_t'{ukl_pkg::ST_MISSING, 1'b0, 4'd0, 32'h0,
                                                5'd14}));
        plan.push_back(plan_row(ukl_pkg::OP_FIND, 32'h0, 4'd0, 1, 0, '0));
        plan.push_back(plan_row(ukl_pkg::OP_DEL_AT, 32'h0, 4'd13, 1, 0, '0));
        plan.push_back(plan_row(OP_RESV5, 32'h0000_1005, 4'd3, 1, 0, '0));
        plan.push_back(plan_row(OP_RESV6, 32'h0000_1006, 4'd0, 1, 0, '0));

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[r])
            for (int c = 0; c < plan[r].copies; c++)
                issue(plan[r].op, plan[r].key + c, plan[r].pos, plan[r].typed, plan[r].want);

        // Random part: alternate spells of filling and draining so that both the full and the
        // empty table are reached again and again, keys often taken from what is stored.
        accepted = 0;
        while (accepted < RANDOM_REQUESTS)
        begin
            quiet   = (accepted >= 300 && accepted < 450);
            filling = ((accepted / 120) % 2) == 0;
            pick    = $urandom_range(0, 99);
            if (filling)
                op = (pick < 50) ? ukl_pkg::OP_ADD : (pick < 60) ? ukl_pkg::OP_DEL_KEY :
                     (pick < 68) ? ukl_pkg::OP_DEL_AT : (pick < 82) ? ukl_pkg::OP_READ_AT :
                     (pick < 96) ? ukl_pkg::OP_FIND : OP_RESV5;
            else
                op = (pick < 15) ? ukl_pkg::OP_ADD : (pick < 40) ? ukl_pkg::OP_DEL_KEY :
                     (pick < 60) ? ukl_pkg::OP_DEL_AT : (pick < 78) ? ukl_pkg::OP_READ_AT :
                     (pick < 96) ? ukl_pkg::OP_FIND : OP_RESV5;

            pick = $urandom_range(0, 9);
            if (pick < 4 && shadow_count > 0)
                key = shadow_keys[$urandom_range(0, shadow_count - 1)];
            else if (pick < 7)
                key = $urandom_range(0, 40);
            else
                key = $urandom;

            if ($urandom_range(0, 3) != 0 && shadow_count > 0)
                pos = POS_W'($urandom_range(0, shadow_count - 1));
            else
                pos = POS_W'($urandom_range(0, 15));

            if (op == OP_RESV5)
            begin
                // Undefined request codes: noise that leaves the table alone.
                op  = OP_W'($urandom_range(OP_RESV5, OP_RESV7));
                key = $urandom;
                pos = POS_W'($urandom_range(0, 15));
            end
            else
                accepted++;
            issue(op, key, pos, 1'b0, '0);
        end
        req_ch.valid <= 1'b0;
        quiet = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: files.f
hdl/ukl_pkg.sv
hdl/ukl_if.sv
hdl/ukl_ram.sv
hdl/ukl_ctrl.sv
hdl/unique_key_list_table.sv
dv/unique_key_list_table_tb.sv
